@@ rtl/stbe_pkg.sv @@
// Package: sizes, command and state codes, memory request type and helpers for the timer bank
`timescale 1ns / 1ps

package stbe_pkg;

    localparam int NUM_TIMERS  = 12;
    localparam int FIRST_EVENT = 9;
    localparam int NUM_EVENTS  = 3;
    localparam int COUNT_WIDTH = 32;

    localparam int ID_W     = $clog2(NUM_TIMERS);
    localparam int SLOT_W   = 2;
    localparam int PERIOD_W = 16;
    localparam int CHECK_W  = 16;
    localparam int TICK_W   = 32;

    localparam logic [COUNT_WIDTH-1:0] DIV10_MAGIC = 32'hCCCC_CCCD;
    localparam int                     DIV10_SHIFT = 35;
    localparam int                     PROD_W      = 2 * COUNT_WIDTH;

    typedef enum logic [2:0] {
        CMD_TICK  = 3'd0,
        CMD_SET   = 3'd1,
        CMD_CHECK = 3'd2,
        CMD_EVENT = 3'd3,
        CMD_KILL  = 3'd4
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TICK,
        ST_CHK_RD,
        ST_CHK_MUL,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic                   rd_en;
        logic [ID_W-1:0]        rd_addr;
        logic                   wr_en;
        logic [ID_W-1:0]        wr_addr;
        logic [COUNT_WIDTH-1:0] wr_data;
    } mem_req_t;

    // id mod 12 through a reciprocal multiply, exact for 8-bit ids
    function automatic logic [ID_W-1:0] timer_index(input logic [7:0] id);
        logic [15:0] q;
        logic [15:0] r;
        q = (16'(id) * 16'd171) >> 11;
        r = 16'(id) - q * 16'(NUM_TIMERS);
        return r[ID_W-1:0];
    endfunction

endpackage

@@ rtl/stbe_ifs.sv @@
// Interfaces: request and response channels of the timer bank
`timescale 1ns / 1ps

interface stbe_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  cmd;
    logic [7:0]  timer_id;
    logic [31:0] count;
    logic [15:0] period;
    logic [7:0]  kill_handle;

    modport source (output valid, output cmd, output timer_id, output count,
                    output period, output kill_handle, input ready);
    modport sink   (input valid, input cmd, input timer_id, input count,
                    input period, input kill_handle, output ready);
endinterface

interface stbe_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] check_value;
    logic [1:0]  slot_given;
    logic        slot_ok;
    logic [2:0]  fired_mask;
    logic [31:0] tick_total;

    modport source (output valid, output check_value, output slot_given, output slot_ok,
                    output fired_mask, output tick_total, input ready);
    modport sink   (input valid, input check_value, input slot_given, input slot_ok,
                    input fired_mask, input tick_total, output ready);
endinterface

@@ rtl/stbe_cnt_mem.sv @@
// Counter memory: one write port, one registered read port, per-entry valid bits
`timescale 1ns / 1ps

module stbe_cnt_mem (
    input  logic                            clk,
    input  logic                            rst_n,
    input  stbe_pkg::mem_req_t              mreq,
    output logic [stbe_pkg::COUNT_WIDTH-1:0] rd_data
);

    logic [stbe_pkg::COUNT_WIDTH-1:0] mem [stbe_pkg::NUM_TIMERS];
    logic [stbe_pkg::NUM_TIMERS-1:0]  valid_reg;
    logic [stbe_pkg::COUNT_WIDTH-1:0] rd_data_reg;
    logic                             rd_ok_reg;

    always_ff @(posedge clk)
    begin
        if (mreq.wr_en)
        begin
            mem[mreq.wr_addr] <= mreq.wr_data;
        end
        if (mreq.rd_en)
        begin
            rd_data_reg <= mem[mreq.rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rd_ok_reg <= 1'b0;
        end
        else
        begin
            if (mreq.wr_en)
            begin
                valid_reg[mreq.wr_addr] <= 1'b1;
            end
            if (mreq.rd_en)
            begin
                rd_ok_reg <= valid_reg[mreq.rd_addr];
            end
        end
    end

    // never-written entries read as zero
    assign rd_data = rd_ok_reg ? rd_data_reg : '0;

endmodule

@@ rtl/soft_timer_bank_with_events.sv @@
// Top level: bank of down-counters with event slots and a free-running tick count
//
//  channel | dir | fields
//  req     | in  | cmd, timer_id, count, period, kill_handle
//  rsp     | out | check_value, slot_given, slot_ok, fired_mask, tick_total
//
//  Tick: the result follows a walk over the twelve counters through the single read
//  port of the counter memory. Check: read, multiply by the reciprocal of ten, result;
//  the multiply step is skipped when the counter is below ten.
//  Set, set event, kill, unknown: accept, then result.
//  One request at a time; a new request is taken while a result waits in the output
//  register, and a finished result holds until that register drains.
//  Reset clears the tick count, slot state and the memory's valid bits at once.
`timescale 1ns / 1ps

module soft_timer_bank_with_events (
    input  logic        clk,
    input  logic        rst_n,
    stbe_req_if.sink    req,
    stbe_rsp_if.source  rsp
);

    stbe_pkg::state_t state_reg, state_next;

    logic [stbe_pkg::ID_W-1:0]        idx_reg, idx_next;
    logic [stbe_pkg::NUM_EVENTS-1:0]  active_reg, active_next;
    logic [stbe_pkg::PERIOD_W-1:0]    period_reg [stbe_pkg::NUM_EVENTS];
    logic [stbe_pkg::PERIOD_W-1:0]    period_next [stbe_pkg::NUM_EVENTS];
    logic [stbe_pkg::TICK_W-1:0]      tick_reg, tick_next;
    logic [stbe_pkg::NUM_EVENTS-1:0]  fired_reg, fired_next;
    logic [stbe_pkg::CHECK_W-1:0]     check_reg, check_next;
    logic [stbe_pkg::SLOT_W-1:0]      given_reg, given_next;
    logic                             ok_reg, ok_next;
    logic [stbe_pkg::PROD_W-1:0]      prod_reg, prod_next;

    logic                             out_valid_reg, out_valid_next;
    logic [stbe_pkg::CHECK_W-1:0]     out_check_reg, out_check_next;
    logic [stbe_pkg::SLOT_W-1:0]      out_given_reg, out_given_next;
    logic                             out_ok_reg, out_ok_next;
    logic [stbe_pkg::NUM_EVENTS-1:0]  out_fired_reg, out_fired_next;
    logic [stbe_pkg::TICK_W-1:0]      out_tick_reg, out_tick_next;

    stbe_pkg::mem_req_t               mreq;
    logic [stbe_pkg::COUNT_WIDTH-1:0] rd_data;

    logic                             accept;
    logic                             out_load;
    logic [stbe_pkg::ID_W-1:0]        req_idx;
    logic                             free_found;
    logic [stbe_pkg::SLOT_W-1:0]      free_slot;
    logic [stbe_pkg::ID_W-1:0]        rel_idx;
    logic [stbe_pkg::SLOT_W-1:0]      walk_slot;
    logic                             walk_is_evt;
    logic [stbe_pkg::COUNT_WIDTH-1:0] dec_val;
    logic                             last_idx;

    stbe_cnt_mem u_cnt_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .mreq    (mreq),
        .rd_data (rd_data)
    );

    assign req.ready = (state_reg == stbe_pkg::ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign out_load  = (state_reg == stbe_pkg::ST_DONE) && (!out_valid_reg || rsp.ready);
    assign req_idx   = stbe_pkg::timer_index(req.timer_id);
    assign rel_idx   = idx_reg - stbe_pkg::ID_W'(stbe_pkg::FIRST_EVENT);
    assign walk_slot = rel_idx[stbe_pkg::SLOT_W-1:0];
    assign walk_is_evt = (idx_reg >= stbe_pkg::ID_W'(stbe_pkg::FIRST_EVENT));
    assign dec_val   = rd_data - 1'b1;
    assign last_idx  = (idx_reg == stbe_pkg::ID_W'(stbe_pkg::NUM_TIMERS - 1));

    always_comb
    begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int s = stbe_pkg::NUM_EVENTS - 1; s >= 0; s--)
        begin
            if (!active_reg[s])
            begin
                free_found = 1'b1;
                free_slot  = stbe_pkg::SLOT_W'(s);
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            stbe_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (stbe_pkg::cmd_t'(req.cmd))
                        stbe_pkg::CMD_TICK:  state_next = stbe_pkg::ST_TICK;
                        stbe_pkg::CMD_CHECK: state_next = stbe_pkg::ST_CHK_RD;
                        default:             state_next = stbe_pkg::ST_DONE;
                    endcase
                end
            end
            stbe_pkg::ST_TICK:
            begin
                if (last_idx)
                begin
                    state_next = stbe_pkg::ST_DONE;
                end
            end
            stbe_pkg::ST_CHK_RD:
            begin
                if (rd_data < stbe_pkg::COUNT_WIDTH'(10))
                begin
                    state_next = stbe_pkg::ST_DONE;
                end
                else
                begin
                    state_next = stbe_pkg::ST_CHK_MUL;
                end
            end
            stbe_pkg::ST_CHK_MUL:
            begin
                state_next = stbe_pkg::ST_DONE;
            end
            stbe_pkg::ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = stbe_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = stbe_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and memory requests
    always_comb
    begin
        idx_next    = idx_reg;
        active_next = active_reg;
        for (int s = 0; s < stbe_pkg::NUM_EVENTS; s++)
        begin
            period_next[s] = period_reg[s];
        end
        tick_next   = tick_reg;
        fired_next  = fired_reg;
        check_next  = check_reg;
        given_next  = given_reg;
        ok_next     = ok_reg;
        prod_next   = prod_reg;
        mreq        = '0;

        case (state_reg)
            stbe_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    check_next = '0;
                    given_next = '0;
                    ok_next    = 1'b0;
                    fired_next = '0;
                    case (stbe_pkg::cmd_t'(req.cmd))
                        stbe_pkg::CMD_TICK:
                        begin
                            tick_next    = tick_reg + 1'b1;
                            idx_next     = '0;
                            mreq.rd_en   = 1'b1;
                            mreq.rd_addr = '0;
                        end
                        stbe_pkg::CMD_SET:
                        begin
                            mreq.wr_en   = 1'b1;
                            mreq.wr_addr = req_idx;
                            mreq.wr_data = req.count;
                        end
                        stbe_pkg::CMD_CHECK:
                        begin
                            mreq.rd_en   = 1'b1;
                            mreq.rd_addr = req_idx;
                        end
                        stbe_pkg::CMD_EVENT:
                        begin
                            if (free_found)
                            begin
                                active_next[free_slot] = 1'b1;
                                period_next[free_slot] = req.period;
                                given_next   = free_slot;
                                ok_next      = 1'b1;
                                mreq.wr_en   = 1'b1;
                                mreq.wr_addr = stbe_pkg::ID_W'(stbe_pkg::FIRST_EVENT)
                                               + stbe_pkg::ID_W'(free_slot);
                                mreq.wr_data = stbe_pkg::COUNT_WIDTH'(req.period);
                            end
                        end
                        stbe_pkg::CMD_KILL:
                        begin
                            if (req.kill_handle < 8'(stbe_pkg::NUM_EVENTS))
                            begin
                                active_next[req.kill_handle[stbe_pkg::SLOT_W-1:0]] = 1'b0;
                                period_next[req.kill_handle[stbe_pkg::SLOT_W-1:0]] = '0;
                                mreq.wr_en   = 1'b1;
                                mreq.wr_addr = stbe_pkg::ID_W'(stbe_pkg::FIRST_EVENT)
                                    + stbe_pkg::ID_W'(req.kill_handle[stbe_pkg::SLOT_W-1:0]);
                                mreq.wr_data = '0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            stbe_pkg::ST_TICK:
            begin
                if (rd_data != '0)
                begin
                    mreq.wr_en   = 1'b1;
                    mreq.wr_addr = idx_reg;
                    mreq.wr_data = dec_val;
                    if (walk_is_evt && (dec_val == '0) && active_reg[walk_slot])
                    begin
                        fired_next[walk_slot] = 1'b1;
                        if (period_reg[walk_slot] != '0)
                        begin
                            mreq.wr_data = stbe_pkg::COUNT_WIDTH'(period_reg[walk_slot]);
                        end
                        else
                        begin
                            active_next[walk_slot] = 1'b0;
                        end
                    end
                end
                if (!last_idx)
                begin
                    idx_next     = idx_reg + 1'b1;
                    mreq.rd_en   = 1'b1;
                    mreq.rd_addr = idx_reg + 1'b1;
                end
            end
            stbe_pkg::ST_CHK_RD:
            begin
                if (rd_data == '0)
                begin
                    check_next = '0;
                end
                else if (rd_data < stbe_pkg::COUNT_WIDTH'(10))
                begin
                    check_next = stbe_pkg::CHECK_W'(1);
                end
                prod_next = stbe_pkg::PROD_W'(rd_data) * stbe_pkg::PROD_W'(stbe_pkg::DIV10_MAGIC);
            end
            stbe_pkg::ST_CHK_MUL:
            begin
                check_next = prod_reg[stbe_pkg::DIV10_SHIFT +: stbe_pkg::CHECK_W];
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !rsp.ready;
        out_check_next = out_check_reg;
        out_given_next = out_given_reg;
        out_ok_next    = out_ok_reg;
        out_fired_next = out_fired_reg;
        out_tick_next  = out_tick_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_check_next = check_reg;
            out_given_next = given_reg;
            out_ok_next    = ok_reg;
            out_fired_next = fired_reg;
            out_tick_next  = tick_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= stbe_pkg::ST_IDLE;
            active_reg    <= '0;
            tick_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int s = 0; s < stbe_pkg::NUM_EVENTS; s++)
            begin
                period_reg[s] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            tick_reg      <= tick_next;
            out_valid_reg <= out_valid_next;
            for (int s = 0; s < stbe_pkg::NUM_EVENTS; s++)
            begin
                period_reg[s] <= period_next[s];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        fired_reg     <= fired_next;
        check_reg     <= check_next;
        given_reg     <= given_next;
        ok_reg        <= ok_next;
        prod_reg      <= prod_next;
        out_check_reg <= out_check_next;
        out_given_reg <= out_given_next;
        out_ok_reg    <= out_ok_next;
        out_fired_reg <= out_fired_next;
        out_tick_reg  <= out_tick_next;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.check_value = out_check_reg;
    assign rsp.slot_given  = out_given_reg;
    assign rsp.slot_ok     = out_ok_reg;
    assign rsp.fired_mask  = out_fired_reg;
    assign rsp.tick_total  = out_tick_reg;

endmodule

@@ tb/tb.sv @@
// Testbench for the timer bank: directed and random requests checked against an internal predictor
`timescale 1ns / 1ps

module tb;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_WAIT  = 30;
    localparam int PHASE_ITEMS = 390;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [7:0]  timer_id;
        logic [31:0] count;
        logic [15:0] period;
        logic [7:0]  kill_handle;
    } bank_req_t;

    typedef struct packed {
        logic [15:0] check_value;
        logic [1:0]  slot_given;
        logic        slot_ok;
        logic [2:0]  fired_mask;
        logic [31:0] tick_total;
    } bank_rsp_t;

    logic clk;
    logic rst_n;

    stbe_req_if req_ch ();
    stbe_rsp_if rsp_ch ();

    soft_timer_bank_with_events u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    logic [stbe_pkg::COUNT_WIDTH-1:0] bank_cnt [stbe_pkg::NUM_TIMERS];
    logic [stbe_pkg::PERIOD_W-1:0]    bank_period [stbe_pkg::NUM_EVENTS];
    logic                             bank_armed [stbe_pkg::NUM_EVENTS];
    logic [stbe_pkg::TICK_W-1:0]      bank_ticks;

    bank_rsp_t   pending_rsps [$];
    int unsigned src_idle_pct;
    int unsigned snk_stall_pct;
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    int unsigned req_count;
    int unsigned rsp_count = 0;
    int unsigned fire_count;
    int unsigned full_bank_count;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic bank_rsp_t timer_bank_response(input bank_req_t r);
        bank_rsp_t                        res;
        int unsigned                      idx;
        int unsigned                      s;
        logic                             found;
        logic [stbe_pkg::COUNT_WIDTH-1:0] c;
        res   = '0;
        idx   = r.timer_id % stbe_pkg::NUM_TIMERS;
        found = 1'b0;
        case (r.cmd)
            stbe_pkg::CMD_TICK:
            begin
                bank_ticks = bank_ticks + 1;
                for (int i = 0; i < stbe_pkg::NUM_TIMERS; i++)
                begin
                    if (bank_cnt[i] != '0)
                    begin
                        bank_cnt[i] = bank_cnt[i] - 1;
                        if (i >= stbe_pkg::FIRST_EVENT && bank_cnt[i] == '0)
                        begin
                            s = i - stbe_pkg::FIRST_EVENT;
                            if (bank_armed[s])
                            begin
                                res.fired_mask[s] = 1'b1;
                                if (bank_period[s] != '0)
                                    bank_cnt[i] = stbe_pkg::COUNT_WIDTH'(bank_period[s]);
                                else
                                    bank_armed[s] = 1'b0;
                            end
                        end
                    end
                end
            end
            stbe_pkg::CMD_SET:
                bank_cnt[idx] = r.count;
            stbe_pkg::CMD_CHECK:
            begin
                c = bank_cnt[idx];
                if (c == '0)
                    res.check_value = '0;
                else if (c >= 10)
                    res.check_value = 16'(c / 10);
                else
                    res.check_value = 16'd1;
            end
            stbe_pkg::CMD_EVENT:
            begin
                for (int k = 0; k < stbe_pkg::NUM_EVENTS; k++)
                begin
                    if (!found && !bank_armed[k])
                    begin
                        found                  = 1'b1;
                        bank_armed[k]          = 1'b1;
                        bank_period[k]         = r.period;
                        bank_cnt[stbe_pkg::FIRST_EVENT + k] =
                            stbe_pkg::COUNT_WIDTH'(r.period);
                        res.slot_given         = stbe_pkg::SLOT_W'(k);
                        res.slot_ok            = 1'b1;
                    end
                end
            end
            stbe_pkg::CMD_KILL:
            begin
                if (r.kill_handle < stbe_pkg::NUM_EVENTS)
                begin
                    s                                   = 32'(r.kill_handle);
                    bank_armed[s]                       = 1'b0;
                    bank_period[s]                      = '0;
                    bank_cnt[stbe_pkg::FIRST_EVENT + s] = '0;
                end
            end
            default:
                ;
        endcase
        res.tick_total = bank_ticks;
        return res;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] want,
                                   input logic [31:0] got);
        begin
            error_count++;
            $display("[%0t] mismatch on response %0d: %s expected 0x%0h, got 0x%0h",
                     $realtime, rsp_count, field, want, got);
        end
    endtask

    task automatic send_req(input logic [2:0] cmd, input logic [7:0] timer_id,
                            input logic [31:0] count, input logic [15:0] period,
                            input logic [7:0] kill_handle);
        bank_req_t r;
        begin
            r = '{cmd, timer_id, count, period, kill_handle};
            while ($urandom_range(99) < src_idle_pct)
            begin
                req_ch.valid <= 1'b0;
                @(posedge clk);
            end
            req_ch.valid       <= 1'b1;
            req_ch.cmd         <= cmd;
            req_ch.timer_id    <= timer_id;
            req_ch.count       <= count;
            req_ch.period      <= period;
            req_ch.kill_handle <= kill_handle;
            @(posedge clk);
            while (!req_ch.ready)
                @(posedge clk);
            pending_rsps.push_back(timer_bank_response(r));
            req_count++;
            if (r.cmd == stbe_pkg::CMD_EVENT && !pending_rsps[$].slot_ok)
                full_bank_count++;
            for (int k = 0; k < stbe_pkg::NUM_EVENTS; k++)
                if (pending_rsps[$].fired_mask[k])
                    fire_count++;
        end
    endtask

    always @(posedge clk)
    begin
        bank_rsp_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_rsps.size() == 0)
            begin
                error_count++;
                $display("[%0t] response with nothing outstanding", $realtime);
            end
            else
            begin
                want = pending_rsps.pop_front();
                if (rsp_ch.check_value !== want.check_value)
                    report_mismatch("check_value", 32'(want.check_value),
                                    32'(rsp_ch.check_value));
                if (rsp_ch.slot_given !== want.slot_given)
                    report_mismatch("slot_given", 32'(want.slot_given),
                                    32'(rsp_ch.slot_given));
                if (rsp_ch.slot_ok !== want.slot_ok)
                    report_mismatch("slot_ok", 32'(want.slot_ok), 32'(rsp_ch.slot_ok));
                if (rsp_ch.fired_mask !== want.fired_mask)
                    report_mismatch("fired_mask", 32'(want.fired_mask),
                                    32'(rsp_ch.fired_mask));
                if (rsp_ch.tick_total !== want.tick_total)
                    report_mismatch("tick_total", want.tick_total, rsp_ch.tick_total);
            end
            rsp_count++;
        end
        rsp_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d responses outstanding",
                     cycle_count, pending_rsps.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic test_timer_load_and_check;
        begin
            send_req(stbe_pkg::CMD_CHECK, 8'd0, 32'd0, 16'd0, 8'd0);
            send_req(stbe_pkg::CMD_SET, 8'd255, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF);
            send_req(stbe_pkg::CMD_CHECK, 8'd3, 32'd0, 16'd0, 8'd0);
            send_req(stbe_pkg::CMD_SET, 8'd0, 32'd9, 16'd0, 8'd0);
            send_req(stbe_pkg::CMD_CHECK, 8'd12, 32'd0, 16'd0, 8'd0);
            send_req(stbe_pkg::CMD_SET, 8'd1, 32'd10, 16'd0, 8'd0);
            send_req(stbe_pkg::CMD_CHECK, 8'd1, 32'd0, 16'd0, 8'd0);
            send_req(stbe_pkg::CMD_SET, 8'd2, 32'd655360, 16'd0, 8'd0);
            send_req(stbe_pkg::CMD_CHECK, 8'd2, 32'd0, 16'd0, 8'd0);
        end
    endtask

    task automatic test_event_slots;
        begin
            send_req(stbe_pkg::CMD_EVENT, 8'd0, 32'd0, 16'd2, 8'd0);
            send_req(stbe_pkg::CMD_EVENT, 8'd0, 32'd0, 16'd0, 8'd0);
            send_req(stbe_pkg::CMD_EVENT, 8'd0, 32'd0, 16'd1, 8'd0);
            send_req(stbe_pkg::CMD_EVENT, 8'd0, 32'd0, 16'hFFFF, 8'd0);
            send_req(stbe_pkg::CMD_TICK, 8'd0, 32'd0, 16'd0, 8'd0);
            send_req(stbe_pkg::CMD_TICK, 8'd0, 32'd0, 16'd0, 8'd0);
            send_req(stbe_pkg::CMD_SET, 8'd9, 32'd3, 16'd0, 8'd0);
            send_req(stbe_pkg::CMD_CHECK, 8'd10, 32'd0, 16'd0, 8'd0);
            send_req(stbe_pkg::CMD_TICK, 8'd0, 32'd0, 16'd0, 8'd0);
        end
    endtask

    task automatic test_kill_and_unknown;
        begin
            send_req(stbe_pkg::CMD_KILL, 8'd0, 32'd0, 16'd0, 8'hFF);
            send_req(stbe_pkg::CMD_KILL, 8'd0, 32'd0, 16'd0, 8'd3);
            send_req(stbe_pkg::CMD_KILL, 8'd0, 32'd0, 16'd0, 8'd2);
            send_req(stbe_pkg::CMD_KILL, 8'd0, 32'd0, 16'd0, 8'd2);
            send_req(3'd5, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF);
            send_req(3'd7, 8'd4, 32'd1, 16'd1, 8'd1);
            send_req(stbe_pkg::CMD_TICK, 8'd0, 32'd0, 16'd0, 8'd0);
        end
    endtask

    task automatic test_random_traffic(input int unsigned n, input int unsigned idle_pct,
                                       input int unsigned stall_pct);
        int unsigned sel;
        logic [2:0]  cmd;
        logic [31:0] count;
        logic [15:0] period;
        logic [7:0]  kh;
        begin
            src_idle_pct  = idle_pct;
            snk_stall_pct = stall_pct;
            repeat (n)
            begin
                sel = $urandom_range(99);
                if (sel < 40)
                    cmd = stbe_pkg::CMD_TICK;
                else if (sel < 52)
                    cmd = stbe_pkg::CMD_SET;
                else if (sel < 68)
                    cmd = stbe_pkg::CMD_CHECK;
                else if (sel < 80)
                    cmd = stbe_pkg::CMD_EVENT;
                else if (sel < 94)
                    cmd = stbe_pkg::CMD_KILL;
                else
                    cmd = 3'($urandom_range(7, 5));
                count  = ($urandom_range(3) == 0) ? $urandom : $urandom_range(40);
                period = ($urandom_range(7) == 0) ? 16'($urandom_range(65535))
                                                  : 16'($urandom_range(6));
                kh     = ($urandom_range(4) == 0) ? 8'($urandom_range(255))
                                                  : 8'($urandom_range(2));
                send_req(cmd, 8'($urandom_range(255)), count, period, kh);
            end
        end
    endtask

    initial
    begin
        rst_n              = 1'b0;
        req_ch.valid       <= 1'b0;
        req_ch.cmd         <= stbe_pkg::CMD_TICK;
        req_ch.timer_id    <= '0;
        req_ch.count       <= '0;
        req_ch.period      <= '0;
        req_ch.kill_handle <= '0;
        src_idle_pct       = 0;
        snk_stall_pct      = 0;
        req_count          = 0;
        fire_count         = 0;
        full_bank_count    = 0;
        bank_ticks         = '0;
        for (int i = 0; i < stbe_pkg::NUM_TIMERS; i++)
            bank_cnt[i] = '0;
        for (int k = 0; k < stbe_pkg::NUM_EVENTS; k++)
        begin
            bank_period[k] = '0;
            bank_armed[k]  = 1'b0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_timer_load_and_check();
        test_event_slots();
        test_kill_and_unknown();
        test_random_traffic(PHASE_ITEMS, 0, 0);
        test_random_traffic(PHASE_ITEMS, 66, 0);
        test_random_traffic(PHASE_ITEMS, 0, 66);
        test_random_traffic(PHASE_ITEMS, 36, 36);
        req_ch.valid <= 1'b0;

        while (pending_rsps.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Sent %0d requests, checked %0d responses, %0d mismatches.",
                 req_count, rsp_count, error_count);
        $display("Ticks counted %0d, event firings %0d, set-event refusals %0d.",
                 bank_ticks, fire_count, full_bank_count);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
